// ===== rtl/newell_polygon_normal_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef NEWELL_POLYGON_NORMAL_DEFINES_SVH
`define NEWELL_POLYGON_NORMAL_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NPN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/npn_pkg.sv =====
package npn_pkg;

  localparam int unsigned POS_WIDTH         = 24;
  localparam int unsigned EDGE_WIDTH        = POS_WIDTH + 1;
  localparam int unsigned MUL_WIDTH         = 33;
  localparam int unsigned PROD_WIDTH        = 2 * MUL_WIDTH;
  localparam int unsigned ACC_WIDTH         = 58;
  localparam int unsigned MAX_POLY_VERTICES = 256;
  localparam int unsigned CNT_WIDTH         = 9;
  localparam int unsigned THR_WIDTH         = 32;
  localparam int unsigned NORM_WIDTH        = 16;
  localparam int unsigned STATUS_WIDTH      = 2;

  typedef logic [STATUS_WIDTH-1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_TOO_FEW   = 2'd1;
  localparam status_t STATUS_DEGENERATE = 2'd2;

endpackage

// ===== rtl/newell_polygon_normal.sv =====
// Newell face normal of one polygon.
// Input channel (in_valid_i/in_ready_o): one vertex per item, signed Q12.12
// x/y/z, last_vertex_i set on the final vertex of the polygon.
// Output channel (out_valid_o/out_ready_i): one item per polygon with the
// Q1.15 unit normal and a status (ok, too few vertices, degenerate face).
// cfg_we_i/cfg_wdata_i write the degenerate threshold; write only when idle.
// All arithmetic goes through one 33x33 multiplier and one wide
// add/compare-subtract unit under a small sequencer, one item at a time.
// A vertex after the first that is not last adds its edge (three products,
// each multiply then accumulate) before the next vertex is taken.
// A last vertex adds its edge and the closing edge, then takes the
// magnitudes, the squared length and the degenerate check, a common shift,
// squares again, a 32-step square root and three divisions before the
// result is shown. A lone vertex adds only the closing edge; a too-few or
// degenerate result skips what follows.
// A result waits in its output register while the receiver stalls; no new
// vertex is taken until it has been delivered.
// Reset clears the accumulators, vertex count and threshold; ready is high
// straight after reset.
module newell_polygon_normal (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [npn_pkg::THR_WIDTH-1:0]         cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [npn_pkg::POS_WIDTH-1:0]  pos_x_i,
  input  logic signed [npn_pkg::POS_WIDTH-1:0]  pos_y_i,
  input  logic signed [npn_pkg::POS_WIDTH-1:0]  pos_z_i,
  input  logic                                  last_vertex_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [npn_pkg::NORM_WIDTH-1:0] normal_x_o,
  output logic signed [npn_pkg::NORM_WIDTH-1:0] normal_y_o,
  output logic signed [npn_pkg::NORM_WIDTH-1:0] normal_z_o,
  output npn_pkg::status_t                      status_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADD   = 4'd2;
  localparam logic [3:0] S_MAG   = 4'd3;
  localparam logic [3:0] S_SQM   = 4'd4;
  localparam logic [3:0] S_SQA   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_SHIFT = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DIVP  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam int unsigned PW  = npn_pkg::POS_WIDTH;
  localparam int unsigned EW  = npn_pkg::EDGE_WIDTH;
  localparam int unsigned MW  = npn_pkg::MUL_WIDTH;
  localparam int unsigned AW  = npn_pkg::ACC_WIDTH;
  localparam int unsigned CW  = npn_pkg::CNT_WIDTH;
  localparam int unsigned NW  = npn_pkg::NORM_WIDTH;
  localparam int unsigned RW  = 47; // division remainder
  localparam logic [CW-1:0] CNT_MAX = CW'(npn_pkg::MAX_POLY_VERTICES);

  logic [3:0]                     state_q;
  logic [1:0]                     t_q;
  logic                           closing_q, last_q, norm_q, big_q;
  logic [CW-1:0]                  count_q;
  logic [npn_pkg::THR_WIDTH-1:0]  thr_q;
  logic signed [PW-1:0]           first_q [3];
  logic signed [PW-1:0]           prev_q  [3];
  logic signed [PW-1:0]           end_q   [3];
  logic [AW-1:0]                  acc_q   [3];
  logic [AW-1:0]                  mag_q   [3];
  logic [2:0]                     neg_q;
  logic signed [npn_pkg::PROD_WIDTH-1:0] prod_q;
  logic [65:0]                    sqsum_q;
  logic [63:0]                    r_q, bit_q;
  logic [RW-1:0]                  rem_q;
  logic [3:0]                     j_q;
  logic [NW-1:0]                  q_q;
  logic signed [NW-1:0]           normal_q [3];
  npn_pkg::status_t               status_q;

  // shared multiplier and its operand selection
  logic signed [EW-1:0] da, sb;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [npn_pkg::PROD_WIDTH-1:0] mul_p;

  always_comb begin
    case (t_q)
      2'd0: begin
        da = {prev_q[1][PW-1], prev_q[1]} - {end_q[1][PW-1], end_q[1]};
        sb = {prev_q[2][PW-1], prev_q[2]} + {end_q[2][PW-1], end_q[2]};
      end
      2'd1: begin
        da = {prev_q[2][PW-1], prev_q[2]} - {end_q[2][PW-1], end_q[2]};
        sb = {prev_q[0][PW-1], prev_q[0]} + {end_q[0][PW-1], end_q[0]};
      end
      default: begin
        da = {prev_q[0][PW-1], prev_q[0]} - {end_q[0][PW-1], end_q[0]};
        sb = {prev_q[1][PW-1], prev_q[1]} + {end_q[1][PW-1], end_q[1]};
      end
    endcase
    if (state_q == S_SQM) begin
      mul_a = {1'b0, mag_q[t_q][31:0]};
      mul_b = {1'b0, mag_q[t_q][31:0]};
    end else begin
      mul_a = {{(MW-EW){da[EW-1]}}, da};
      mul_b = {{(MW-EW){sb[EW-1]}}, sb};
    end
    mul_p = mul_a * mul_b;
  end

  // wide add/compare datapath
  logic [AW-1:0] mag_nx;
  logic [63:0]   rb;
  logic [RW-1:0] dvs;
  logic          take;
  logic [NW-1:0] q_nx, q_sat;
  logic          degen;

  always_comb begin
    mag_nx = acc_q[t_q][AW-1] ? (~acc_q[t_q] + AW'(1)) : acc_q[t_q];
    rb     = r_q + bit_q;
    dvs    = RW'(r_q[31:0]) << j_q;
    take   = rem_q >= dvs;
    q_nx   = q_q;
    q_nx[j_q] = take;
    if (neg_q[t_q]) begin
      q_sat = (q_nx > NW'(32768)) ? NW'(32768) : q_nx;
      q_sat = NW'(0) - q_sat;
    end else begin
      q_sat = (q_nx > NW'(32767)) ? NW'(32767) : q_nx;
    end
    degen = !(big_q || (sqsum_q[65:64] != 2'b00)) && (sqsum_q[63:0] <= 64'(thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      t_q       <= 2'd0;
      closing_q <= 1'b0;
      last_q    <= 1'b0;
      norm_q    <= 1'b0;
      big_q     <= 1'b0;
      count_q   <= '0;
      thr_q     <= '0;
      neg_q     <= '0;
      prod_q    <= '0;
      sqsum_q   <= '0;
      r_q       <= '0;
      bit_q     <= '0;
      rem_q     <= '0;
      j_q       <= '0;
      q_q       <= '0;
      status_q  <= npn_pkg::STATUS_OK;
      for (int i = 0; i < 3; i++) begin
        first_q[i]  <= '0;
        prev_q[i]   <= '0;
        end_q[i]    <= '0;
        acc_q[i]    <= '0;
        mag_q[i]    <= '0;
        normal_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q <= last_vertex_i;
            t_q    <= 2'd0;
            if (count_q < CNT_MAX) begin
              count_q <= count_q + CW'(1);
              if (count_q == '0) begin
                first_q[0] <= pos_x_i;
                first_q[1] <= pos_y_i;
                first_q[2] <= pos_z_i;
                prev_q[0]  <= pos_x_i;
                prev_q[1]  <= pos_y_i;
                prev_q[2]  <= pos_z_i;
                end_q[0]   <= pos_x_i;
                end_q[1]   <= pos_y_i;
                end_q[2]   <= pos_z_i;
                closing_q  <= 1'b1;
                if (last_vertex_i) begin
                  state_q <= S_MUL;
                end
              end else begin
                end_q[0]  <= pos_x_i;
                end_q[1]  <= pos_y_i;
                end_q[2]  <= pos_z_i;
                closing_q <= 1'b0;
                state_q   <= S_MUL;
              end
            end else if (last_vertex_i) begin
              // vertex over the limit: only its flag counts
              end_q     <= first_q;
              closing_q <= 1'b1;
              state_q   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod_q  <= mul_p;
          state_q <= S_ADD;
        end
        S_ADD: begin
          acc_q[t_q] <= acc_q[t_q] + prod_q[AW-1:0];
          if (t_q != 2'd2) begin
            t_q     <= t_q + 2'd1;
            state_q <= S_MUL;
          end else begin
            t_q <= 2'd0;
            if (!closing_q) begin
              prev_q <= end_q;
              if (last_q) begin
                end_q     <= first_q;
                closing_q <= 1'b1;
                state_q   <= S_MUL;
              end else begin
                state_q <= S_IDLE;
              end
            end else if (count_q < CW'(3)) begin
              status_q <= npn_pkg::STATUS_TOO_FEW;
              for (int i = 0; i < 3; i++) normal_q[i] <= '0;
              state_q <= S_OUT;
            end else begin
              big_q   <= 1'b0;
              norm_q  <= 1'b0;
              sqsum_q <= '0;
              state_q <= S_MAG;
            end
          end
        end
        S_MAG: begin
          mag_q[t_q]  <= mag_nx;
          neg_q[t_q]  <= acc_q[t_q][AW-1];
          if (t_q != 2'd2) begin
            t_q <= t_q + 2'd1;
          end else begin
            t_q     <= 2'd0;
            state_q <= S_SQM;
          end
        end
        S_SQM: begin
          if (mag_q[t_q][AW-1:32] != '0) begin
            big_q <= 1'b1;
          end
          prod_q  <= mul_p;
          state_q <= S_SQA;
        end
        S_SQA: begin
          if (mag_q[t_q][AW-1:32] == '0) begin
            sqsum_q <= sqsum_q + 66'(prod_q[63:0]);
          end
          if (t_q != 2'd2) begin
            t_q     <= t_q + 2'd1;
            state_q <= S_SQM;
          end else begin
            t_q <= 2'd0;
            if (norm_q) begin
              r_q     <= '0;
              bit_q   <= 64'h4000_0000_0000_0000;
              state_q <= S_SQRT;
            end else begin
              state_q <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (degen) begin
            status_q <= npn_pkg::STATUS_DEGENERATE;
            for (int i = 0; i < 3; i++) normal_q[i] <= '0;
            state_q <= S_OUT;
          end else begin
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // common right shift until every magnitude is below 2^30
          if ((mag_q[0][AW-1:30] != '0) || (mag_q[1][AW-1:30] != '0) ||
              (mag_q[2][AW-1:30] != '0)) begin
            for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
          end else begin
            sqsum_q <= '0;
            norm_q  <= 1'b1;
            t_q     <= 2'd0;
            state_q <= S_SQM;
          end
        end
        S_SQRT: begin
          if (sqsum_q[63:0] >= rb) begin
            sqsum_q <= {2'b00, sqsum_q[63:0] - rb};
            r_q     <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) begin
            t_q     <= 2'd0;
            state_q <= S_DIVP;
          end
        end
        S_DIVP: begin
          if (r_q == '0) begin
            status_q <= npn_pkg::STATUS_DEGENERATE;
            for (int i = 0; i < 3; i++) normal_q[i] <= '0;
            state_q <= S_OUT;
          end else begin
            status_q <= npn_pkg::STATUS_OK;
            rem_q    <= {2'b00, mag_q[t_q][29:0], 15'd0} + RW'(r_q[31:1]);
            j_q      <= 4'd15;
            q_q      <= '0;
            state_q  <= S_DIV;
          end
        end
        S_DIV: begin
          if (take) begin
            rem_q <= rem_q - dvs;
          end
          q_q <= q_nx;
          j_q <= j_q - 4'd1;
          if (j_q == 4'd0) begin
            normal_q[t_q] <= q_sat;
            if (t_q != 2'd2) begin
              t_q     <= t_q + 2'd1;
              state_q <= S_DIVP;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            count_q   <= '0;
            closing_q <= 1'b0;
            t_q       <= 2'd0;
            for (int i = 0; i < 3; i++) begin
              acc_q[i]   <= '0;
              first_q[i] <= '0;
              prev_q[i]  <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign normal_x_o  = normal_q[0];
  assign normal_y_o  = normal_q[1];
  assign normal_z_o  = normal_q[2];
  assign status_o    = status_q;

endmodule

// ===== rtl/npn_checker.sv =====
`include "newell_polygon_normal_defines.svh"

module npn_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [npn_pkg::NORM_WIDTH-1:0] normal_x_o,
  input logic signed [npn_pkg::NORM_WIDTH-1:0] normal_y_o,
  input logic signed [npn_pkg::NORM_WIDTH-1:0] normal_z_o,
  input npn_pkg::status_t                      status_o
);

  // an accepted item always needs work before any result can show
  `NPN_ASSERT_NEXT(a_accept_no_result, in_valid_i && in_ready_o, !out_valid_o,
                   "result right after accept")

  // a pending result blocks the input side
  `NPN_ASSERT(a_result_blocks_input, out_valid_o, !in_ready_o, "input ready while result pending")

  // error results carry a zero normal
  `NPN_ASSERT(a_error_zero_normal, out_valid_o && (status_o != npn_pkg::STATUS_OK),
              (normal_x_o == 16'sd0) && (normal_y_o == 16'sd0) && (normal_z_o == 16'sd0),
              "nonzero normal on error")

  `NPN_ASSERT(a_status_code, out_valid_o,
              (status_o == npn_pkg::STATUS_OK) || (status_o == npn_pkg::STATUS_TOO_FEW) ||
              (status_o == npn_pkg::STATUS_DEGENERATE), "bad status code")

  `NPN_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(status_o) && $stable(normal_x_o),
                   "stalled result changed")

endmodule

bind newell_polygon_normal npn_checker u_npn_checker (.*);
